FILE: sv/life_grid_generation_step_top_defines.svh
// Assertion helpers shared by the life grid RTL.
`ifndef LIFE_GRID_GENERATION_STEP_TOP_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LGS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("life grid check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("life grid check failed");

`endif

FILE: sv/lgs_pkg.sv
`default_nettype none
package lgs_pkg;

    localparam int unsigned GRID_SIZE = 32;

    // Wide enough to hold any grid size up to 64 for index compares
    localparam int unsigned IDX_CMP_W = 7;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef logic [GRID_SIZE-1:0] row_t;

    typedef struct packed {
        logic step;
        logic wr;
        logic wr_val;
        row_t col_sel;
    } lgs_ctrl_t;

    function automatic logic life_rule(input logic self_alive, input logic [3:0] live);
        logic nxt;
        nxt = (live == BIRTH_COUNT) || (self_alive && (live == SURVIVE_COUNT));
        return nxt;
    endfunction

endpackage
`default_nettype wire

FILE: sv/lgs_row.sv
`default_nettype none
module lgs_row (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lgs_pkg::lgs_ctrl_t ctrl,
    input  wire logic              row_hit,
    input  wire lgs_pkg::row_t     above,
    input  wire lgs_pkg::row_t     below,
    output lgs_pkg::row_t          cells,
    output logic                   rd_bit
);

    lgs_pkg::row_t                      row_reg;
    lgs_pkg::row_t                      row_next;
    logic [lgs_pkg::GRID_SIZE+1:0]      a_pad;
    logic [lgs_pkg::GRID_SIZE+1:0]      m_pad;
    logic [lgs_pkg::GRID_SIZE+1:0]      b_pad;
    logic [3:0]                         live [lgs_pkg::GRID_SIZE];
    lgs_pkg::row_t                      gen_row;

    // Pad with dead cells so the edge columns see no neighbors outside the grid
    assign a_pad = {1'b0, above, 1'b0};
    assign m_pad = {1'b0, row_reg, 1'b0};
    assign b_pad = {1'b0, below, 1'b0};

    always_comb
    begin
        for (int c = 0; c < lgs_pkg::GRID_SIZE; c++)
        begin
            live[c] = 4'(a_pad[c]) + 4'(a_pad[c+1]) + 4'(a_pad[c+2])
                    + 4'(m_pad[c]) + 4'(m_pad[c+2])
                    + 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2]);
            gen_row[c] = lgs_pkg::life_rule(row_reg[c], live[c]);
        end
    end

    always_comb
    begin
        row_next = row_reg;
        if (ctrl.step)
        begin
            row_next = gen_row;
        end
        else if (ctrl.wr && row_hit)
        begin
            row_next = (row_reg & ~ctrl.col_sel) | (ctrl.col_sel & {lgs_pkg::GRID_SIZE{ctrl.wr_val}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign cells  = row_reg;
    assign rd_bit = row_hit & (|(row_reg & ctrl.col_sel));

endmodule
`default_nettype wire

FILE: sv/life_grid_generation_step_top.sv
// A result beat is registered and appears in the cycle after its input beat is
// accepted. Throughput: one beat per cycle; a read, a write or a full generation
// each complete within one beat because every grid row is its own register cell.
// The input stalls only while a finished result waits on m_axis_tready.
// Reset clears every cell to dead and empties the result register.
`default_nettype none
`include "life_grid_generation_step_top_defines.svh"
module life_grid_generation_step_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // row[4:0], col[9:5], cell_in[10], zero fill
    input  wire logic [1:0] s_axis_tuser,   // opcode[1:0]
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // cell_out[0], zero fill
);

    localparam int unsigned G = lgs_pkg::GRID_SIZE;

    logic [4:0]          row;
    logic [4:0]          col;
    logic                cell_in;
    logic [1:0]          opcode;
    logic                s_accept;
    lgs_pkg::row_t       row_sel;
    lgs_pkg::lgs_ctrl_t  ctrl;
    lgs_pkg::row_t       rows [G];
    lgs_pkg::row_t       rd_bits;
    logic [G*G-1:0]      grid_flat;
    logic                any_alive;
    logic                in_grid;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                cell_out_reg;
    logic                cell_out_next;

    assign row     = s_axis_tdata[4:0];
    assign col     = s_axis_tdata[9:5];
    assign cell_in = s_axis_tdata[10];
    assign opcode  = s_axis_tuser;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // One-hot selects; an index past the grid edge selects nothing
    always_comb
    begin
        for (int r = 0; r < G; r++)
        begin
            row_sel[r] = ({2'b00, row} == lgs_pkg::IDX_CMP_W'(r));
        end
        ctrl.step   = s_accept && (opcode == lgs_pkg::OP_STEP);
        ctrl.wr     = s_accept && (opcode == lgs_pkg::OP_WRITE);
        ctrl.wr_val = cell_in;
        for (int c = 0; c < G; c++)
        begin
            ctrl.col_sel[c] = ({2'b00, col} == lgs_pkg::IDX_CMP_W'(c));
        end
    end

    assign in_grid = (|row_sel) && (|ctrl.col_sel);

    for (genvar r = 0; r < G; r++)
    begin : g_row
        lgs_pkg::row_t above;
        lgs_pkg::row_t below;

        if (r == 0)
        begin : g_top
            assign above = '0;
        end
        else
        begin : g_mid_a
            assign above = rows[r-1];
        end

        if (r == G - 1)
        begin : g_bot
            assign below = '0;
        end
        else
        begin : g_mid_b
            assign below = rows[r+1];
        end

        lgs_row u_row (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .row_hit (row_sel[r]),
            .above   (above),
            .below   (below),
            .cells   (rows[r]),
            .rd_bit  (rd_bits[r])
        );

        assign grid_flat[r*G +: G] = rows[r];
    end

    assign any_alive = |grid_flat;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        cell_out_next  = cell_out_reg;
        if (s_accept)
        begin
            out_valid_next = 1'b1;
            cell_out_next  = (opcode == lgs_pkg::OP_READ) && (|rd_bits);
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_out_reg <= cell_out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, cell_out_reg};

    `LGS_ASSERT_NEXT(a_nonread_zero, s_accept && (opcode != lgs_pkg::OP_READ),
        m_axis_tdata[0] == 1'b0)
    `LGS_ASSERT_NEXT(a_read_after_write, s_accept && (opcode == lgs_pkg::OP_WRITE) && in_grid,
        (s_accept && (opcode == lgs_pkg::OP_READ) && (s_axis_tdata[9:0] == $past(s_axis_tdata[9:0])))
        |=> (m_axis_tdata[0] == $past(s_axis_tdata[10], 2)))
    `LGS_ASSERT_NEXT(a_empty_stays_empty, ctrl.step && !any_alive, !any_alive)
    `LGS_ASSERT_NEXT(a_outside_write_ignored, ctrl.wr && !in_grid, grid_flat == $past(grid_flat))
    `LGS_ASSERT_SAME(a_read_hit_in_grid, |rd_bits, in_grid)

endmodule
`default_nettype wire
